FILE: rtl/rupq_pkg.sv
// Package for the two-dimensional rectangle-update / point-query tree.
// Holds the channel payload types, the internal command type and register indexes.
// No dependencies.
package rupq_pkg;

   localparam int COORD_W = 5;
   localparam int DATA_W  = 64;
   localparam int STAMP_W = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_COMBINE_KIND  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VALUE = 1'd1;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   typedef struct packed {
      logic                      mode;
      logic [COORD_W-1:0]        row_a;
      logic [COORD_W-1:0]        col_a;
      logic [COORD_W-1:0]        row_b;
      logic [COORD_W-1:0]        col_b;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  cell_value;
      logic                      bad_request;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_REJECT,
      CMD_UPDATE,
      CMD_QUERY
   } cmd_kind_type;

   // For a query, row_lo and col_lo carry the queried cell.
   typedef struct packed {
      cmd_kind_type              kind;
      logic [COORD_W-1:0]        row_lo;
      logic [COORD_W-1:0]        row_hi;
      logic [COORD_W-1:0]        col_lo;
      logic [COORD_W-1:0]        col_hi;
      logic [DATA_W-1:0]         value;
   } cmd_type;

endpackage

FILE: rtl/rupq_front.sv
// Front end: classifies an incoming beat into update, query or rejection.
// Depends on rupq_pkg.
module rupq_front import rupq_pkg::*; #(
   parameter int PR = 32,
   parameter int PC = 32
) (
   input  req_type req,
   output cmd_type cmd
);

   logic [COORD_W-1:0] row_lo, row_hi, col_lo, col_hi;
   logic               upd_bad, qry_bad;

   always_comb begin
      row_lo = (req.row_a < req.row_b) ? req.row_a : req.row_b;
      row_hi = (req.row_a < req.row_b) ? req.row_b : req.row_a;
      col_lo = (req.col_a < req.col_b) ? req.col_a : req.col_b;
      col_hi = (req.col_a < req.col_b) ? req.col_b : req.col_a;
      upd_bad = (req.row_a == req.row_b) || (req.col_a == req.col_b) ||
                (32'(row_hi) >= PR) || (32'(col_hi) >= PC);
      qry_bad = (32'(req.row_a) >= PR) || (32'(req.col_a) >= PC);

      cmd.value = req.value;
      if (req.mode == MODE_QUERY) begin
         cmd.kind   = qry_bad ? CMD_REJECT : CMD_QUERY;
         cmd.row_lo = req.row_a;
         cmd.row_hi = req.row_a;
         cmd.col_lo = req.col_a;
         cmd.col_hi = req.col_a;
      end else begin
         cmd.kind   = upd_bad ? CMD_REJECT : CMD_UPDATE;
         cmd.row_lo = row_lo;
         cmd.row_hi = row_hi;
         cmd.col_lo = col_lo;
         cmd.col_hi = col_hi;
      end
   end

endmodule

FILE: rtl/rupq_cmdq.sv
// Two-entry command queue between the front end and the tree engine.
// Depends on rupq_pkg.
module rupq_cmdq import rupq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_cmd;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

FILE: rtl/rupq_back.sv
// Tree engine: walks canonical row and column nodes for updates and ancestor nodes for queries.
// Also runs the clearing pass after reset. Depends on rupq_pkg.
module rupq_back import rupq_pkg::*; #(
   parameter int PR = 32,
   parameter int PC = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   input  logic              asn_mode,
   input  logic [DATA_W-1:0] init_value,
   output logic              clearing,
   output logic              rsp_valid,
   output rsp_type           rsp
);

   localparam int RW = $clog2(PR) + 1;
   localparam int CW = $clog2(PC) + 1;
   localparam int AW = RW + CW;
   localparam int NODES = 1 << AW;
   localparam int EW = STAMP_W + DATA_W;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_ROW, S_COL, S_ADD, S_QRY, S_QLAST
   } state_type;

   state_type             state_ff;
   logic [AW-1:0]         clr_addr_ff, addr_ff;
   logic [RW-1:0]         rl_ff, rr_ff, rnode_ff, qi_ff;
   logic [CW-1:0]         cl_ff, cr_ff, cl0_ff, cr0_ff, qj_ff, qj0_ff;
   logic                  rph_ff, cph_ff, rd_valid_ff, rsp_valid_ff;
   logic [DATA_W-1:0]     value_ff, acc_ff, best_val_ff;
   logic [STAMP_W-1:0]    stamp_ff, stamp_cnt_ff, best_stamp_ff;
   logic [EW-1:0]         rd_data_ff;
   rsp_type               rsp_ff;
   logic [EW-1:0]         mem [NODES];

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [EW-1:0]         mem_wdata;

   logic                  row_done, rw_emit, rph_in;
   logic [RW-1:0]         rw_node, rl_in, rr_in;
   logic                  col_done, cw_emit, cph_in;
   logic [CW-1:0]         cw_node, cl_in, cr_in;

   logic [DATA_W-1:0]     acc_in, best_val_in;
   logic [STAMP_W-1:0]    best_stamp_in;

   assign clearing  = (state_ff == S_CLR);
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // One step of the bottom-up canonical cover: the left bound is examined in the first phase,
   // the right bound and the move up a level in the second.
   always_comb begin
      row_done = !rph_ff && !(rl_ff < rr_ff);
      if (!rph_ff) begin
         rw_emit = rl_ff[0];
         rw_node = rl_ff;
         rl_in   = rl_ff[0] ? rl_ff + RW'(1) : rl_ff;
         rr_in   = rr_ff;
      end else begin
         rw_emit = rr_ff[0];
         rw_node = rr_ff - RW'(1);
         rl_in   = rl_ff >> 1;
         rr_in   = (rr_ff[0] ? rr_ff - RW'(1) : rr_ff) >> 1;
      end
      rph_in = ~rph_ff;

      col_done = !cph_ff && !(cl_ff < cr_ff);
      if (!cph_ff) begin
         cw_emit = cl_ff[0];
         cw_node = cl_ff;
         cl_in   = cl_ff[0] ? cl_ff + CW'(1) : cl_ff;
         cr_in   = cr_ff;
      end else begin
         cw_emit = cr_ff[0];
         cw_node = cr_ff - CW'(1);
         cl_in   = cl_ff >> 1;
         cr_in   = (cr_ff[0] ? cr_ff - CW'(1) : cr_ff) >> 1;
      end
      cph_in = ~cph_ff;
   end

   // Query accumulation on the word read in the previous cycle.
   always_comb begin
      acc_in = acc_ff + rd_data_ff[DATA_W-1:0];
      if (rd_data_ff[EW-1:DATA_W] > best_stamp_ff) begin
         best_val_in   = rd_data_ff[DATA_W-1:0];
         best_stamp_in = rd_data_ff[EW-1:DATA_W];
      end else begin
         best_val_in   = best_val_ff;
         best_stamp_in = best_stamp_ff;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      mem_raddr = {rnode_ff, cw_node};
      case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         S_COL: begin
            mem_waddr = {rnode_ff, cw_node};
            mem_wdata = {stamp_ff, value_ff};
            mem_we    = asn_mode && !col_done && cw_emit;
         end
         S_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = {rd_data_ff[EW-1:DATA_W], rd_data_ff[DATA_W-1:0] + value_ff};
         end
         S_QRY: begin
            mem_raddr = {qi_ff, qj_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_addr_ff  <= '0;
         stamp_cnt_ff <= STAMP_W'(1);
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= (state_ff == S_QRY);
         case (state_ff)
            S_CLR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == {AW{1'b1}}) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  value_ff <= cmd.value;
                  case (cmd.kind)
                     CMD_QUERY: begin
                        qi_ff         <= RW'(32'(cmd.row_lo) + PR);
                        qj_ff         <= CW'(32'(cmd.col_lo) + PC);
                        qj0_ff        <= CW'(32'(cmd.col_lo) + PC);
                        acc_ff        <= init_value;
                        best_val_ff   <= init_value;
                        best_stamp_ff <= '0;
                        state_ff      <= S_QRY;
                     end
                     CMD_UPDATE: begin
                        if (asn_mode && stamp_cnt_ff == '0) begin
                           rsp_ff       <= '{cell_value: '0, bad_request: 1'b1};
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           if (asn_mode) begin
                              stamp_ff     <= stamp_cnt_ff;
                              stamp_cnt_ff <= stamp_cnt_ff + STAMP_W'(1);
                           end
                           rl_ff    <= RW'(32'(cmd.row_lo) + PR);
                           rr_ff    <= RW'(32'(cmd.row_hi) + PR);
                           rph_ff   <= 1'b0;
                           cl0_ff   <= CW'(32'(cmd.col_lo) + PC);
                           cr0_ff   <= CW'(32'(cmd.col_hi) + PC);
                           state_ff <= S_ROW;
                        end
                     end
                     default: begin
                        rsp_ff       <= '{cell_value: '0, bad_request: 1'b1};
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_ROW: begin
               if (row_done) begin
                  rsp_ff       <= '{cell_value: '0, bad_request: 1'b0};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  rl_ff  <= rl_in;
                  rr_ff  <= rr_in;
                  rph_ff <= rph_in;
                  if (rw_emit) begin
                     rnode_ff <= rw_node;
                     cl_ff    <= cl0_ff;
                     cr_ff    <= cr0_ff;
                     cph_ff   <= 1'b0;
                     state_ff <= S_COL;
                  end
               end
            end
            S_COL: begin
               if (col_done) begin
                  state_ff <= S_ROW;
               end else begin
                  cl_ff  <= cl_in;
                  cr_ff  <= cr_in;
                  cph_ff <= cph_in;
                  if (cw_emit && !asn_mode) begin
                     addr_ff  <= {rnode_ff, cw_node};
                     state_ff <= S_ADD;
                  end
               end
            end
            S_ADD: begin
               state_ff <= S_COL;
            end
            S_QRY: begin
               if (rd_valid_ff) begin
                  acc_ff        <= acc_in;
                  best_val_ff   <= best_val_in;
                  best_stamp_ff <= best_stamp_in;
               end
               if (qj_ff == CW'(1)) begin
                  if (qi_ff == RW'(1)) begin
                     state_ff <= S_QLAST;
                  end else begin
                     qi_ff <= qi_ff >> 1;
                     qj_ff <= qj0_ff;
                  end
               end else begin
                  qj_ff <= qj_ff >> 1;
               end
            end
            S_QLAST: begin
               rsp_ff       <= '{cell_value: asn_mode ? best_val_in : acc_in,
                                 bad_request: 1'b0};
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/rect_update_point_query_2d_segtree_top.sv
// A query reads the node for every pair of row and column ancestors of its cell. An update
// walks the row-tree steps and, for each covered row node, the column-tree steps, with one
// more read-modify-write step per covered node in add mode.
// One item is worked at a time by the tree engine over one node memory; two more wait.
// After reset, busy stays high while the node memory is cleared.
// Results carry no back-pressure: each is shown for one cycle on rsp_valid.
module rect_update_point_query_2d_segtree_top import rupq_pkg::*; #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req,
   output logic                 rsp_valid,
   output rsp_type              rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int PR = 1 << $clog2(ROWS);
   localparam int PC = 1 << $clog2(COLS);

   logic              combine_kind_ff;
   logic [DATA_W-1:0] initial_value_ff;
   cmd_type           front_cmd, head_cmd;
   logic              q_full, q_valid, q_pop, clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         combine_kind_ff  <= 1'b0;
         initial_value_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COMBINE_KIND:  combine_kind_ff  <= csr_wdata[0];
            CSR_INITIAL_VALUE: initial_value_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign busy = q_full || clearing;

   rupq_front #(.PR(PR), .PC(PC)) u_front (
      .req (req),
      .cmd (front_cmd)
   );

   rupq_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !busy),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (head_cmd)
   );

   rupq_back #(.PR(PR), .PC(PC)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (head_cmd),
      .cmd_pop    (q_pop),
      .asn_mode   (combine_kind_ff),
      .init_value (initial_value_ff),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

endmodule

FILE: rtl/rupq_checker.sv
// Port-level checks for the tree block, with the bind that attaches them.
// Depends on rupq_pkg and the top level.
module rupq_checker import rupq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp
);

   logic [1:0] pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_ff + {1'b0, start && !busy} - {1'b0, rsp_valid};
      end
   end

   // The memory clearing pass holds the block busy right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy) else $error("busy low right after reset");

   // Every result beat answers an earlier accepted beat.
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0) else $error("result without a request");

   // At most one item in work plus two queued.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3 || busy) else $error("too many items in flight");

   // A rejected beat carries a zero value.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.bad_request |-> rsp.cell_value == '0)
      else $error("rejected beat with nonzero value");

endmodule

bind rect_update_point_query_2d_segtree_top rupq_checker u_rupq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
